/* rtl/rsd_pkg.sv */
`timescale 1ns / 1ps

package rsd_pkg;

  localparam int SYMBOL_DEPTH_DEF  = 256;
  localparam int SECTION_COUNT_DEF = 5;

  // Result queue between the decode stage and the output channel.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Input item kinds, carried on s_axis_tuser.
  localparam logic [1:0] KIND_STREAM  = 2'd0;
  localparam logic [1:0] KIND_SYMBOL  = 2'd1;
  localparam logic [1:0] KIND_SECTION = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ESCAPE    = 2'd0;
  localparam logic [1:0] REG_SYM_COUNT = 2'd1;
  localparam logic [1:0] REG_RUN_LEN   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_SECTION = 2'd1;
  localparam logic [1:0] STAT_RUN        = 2'd2;

  typedef enum logic [4:0] {
    PH_NORMAL  = 5'b00001,
    PH_CODE_LO = 5'b00010,
    PH_CODE_HI = 5'b00100,
    PH_OFF_LO  = 5'b01000,
    PH_OFF_HI  = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    JOB_NONE = 3'd0,
    JOB_BYTE = 3'd1,
    JOB_FAIL = 3'd2,
    JOB_SYM  = 3'd3,
    JOB_SEC  = 3'd4
  } job_kind_t;

  // Work handed from the accept stage to the result stage.
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [15:0] offset;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic [1:0] status;
  } res_t;

endpackage

/* rtl/relocation_stream_decoder.sv */
`timescale 1ns / 1ps

// Relocation stream decoder.
// Input channel s_axis: tuser selects the item kind (stream byte, symbol table
// write, section table write); tdata carries the byte, table index, value and
// section size. Output channel m_axis: one decoded byte per request, tlast on
// the final byte of a run and on every error, tuser with a data flag and status.
// Configuration goes through cfg_we/cfg_index/cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce. Writing
// the run length starts a new run. An accepted item is registered as a job; the
// result stage then writes its results into the result queue, which offers them
// on m_axis. Throughput: one item per cycle for copied bytes and table writes
// while the result queue has room. An address item yields two output bytes, so
// the single output port limits the rate of such items. A code in the section
// range holds tready low while the section ranges are searched.
// The result queue holds four results; tready drops when it cannot take the
// worst case of the items in flight, so a stalled receiver never loses data.
// Reset clears the parse state, the run counter and the registers; table
// contents are undefined until written.
module relocation_stream_decoder #(
  parameter int SYMBOL_DEPTH  = rsd_pkg::SYMBOL_DEPTH_DEF,
  parameter int SECTION_COUNT = rsd_pkg::SECTION_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // in_byte [7:0], table_index [15:8], word_value [31:16], word_size [47:32]
  input  logic [47:0] s_axis_tdata,
  // kind [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte [7:0]
  output logic [7:0]  m_axis_tdata,
  // byte_valid [0], status [2:1]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
  localparam int SEC_W = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam logic [16:0] DEPTH17 = 17'(SYMBOL_DEPTH);

  // Configuration and parse state
  logic [7:0]           escape;
  logic [8:0]           symbol_count;
  rsd_pkg::phase_t      phase, phase_next;
  logic [7:0]           code_low, code_low_next;
  logic [IDX_W-1:0]     pending, pending_next;
  logic [15:0]          bytes_left, bytes_left_next;
  logic                 err_hold, err_hold_next;

  // Tables
  logic [15:0]          sym_mem [SYMBOL_DEPTH];
  logic [15:0]          sym_rdata;
  logic [IDX_W-1:0]     rd_addr;
  logic [15:0]          sec_base [SECTION_COUNT];
  logic [15:0]          sec_size [SECTION_COUNT];

  // Stages
  rsd_pkg::job_t        job, job_in;
  rsd_pkg::res_t        res0, res1;
  logic [1:0]           n_push;
  logic [1:0]           job_cost;
  rsd_pkg::res_t        fifo_mem [rsd_pkg::FIFO_DEPTH];
  logic [rsd_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [rsd_pkg::FIFO_CW-1:0] fifo_count;

  logic                 accept_in, pop;
  logic [7:0]           in_byte, tbl_idx;
  logic [15:0]          word_value, word_size;
  logic [12:0]          tbl_idx13;
  logic [16:0]          sym_eff, e1, e2, e3;
  logic [15:0]          code, bytes_m1, bytes_m2;
  logic                 room_ok;

  logic [15:0]          sec_rem, sec_addr, sym_addr;
  logic                 sec_hit;

  assign in_byte    = s_axis_tdata[7:0];
  assign tbl_idx    = s_axis_tdata[15:8];
  assign word_value = s_axis_tdata[31:16];
  assign word_size  = s_axis_tdata[47:32];
  assign tbl_idx13  = {5'b0, tbl_idx};

  // Room for this item's results after the job in flight has pushed its own.
  assign job_cost = (job.kind == rsd_pkg::JOB_SYM || job.kind == rsd_pkg::JOB_SEC) ? 2'd2 :
                    (job.kind == rsd_pkg::JOB_NONE) ? 2'd0 : 2'd1;
  assign s_axis_tready = (job.kind != rsd_pkg::JOB_SEC) &&
                         ((fifo_count + {1'b0, job_cost}) <= 3'(rsd_pkg::FIFO_DEPTH - 2));
  assign accept_in = s_axis_tvalid && s_axis_tready;

  assign sym_eff  = ({8'b0, symbol_count} < DEPTH17) ? {8'b0, symbol_count} : DEPTH17;
  assign code     = {in_byte, code_low};
  assign e1       = {1'b0, code} - 17'd1;
  assign e2       = e1 - sym_eff;
  assign e3       = e2 - sym_eff;
  assign bytes_m1 = bytes_left - 16'd1;
  assign bytes_m2 = bytes_left - 16'd2;
  assign room_ok  = bytes_left >= 16'd2;

  // Section range search over the job's offset past the symbol bands.
  always_comb begin
    sec_rem  = job.offset;
    sec_hit  = 1'b0;
    sec_addr = '0;
    for (int i = 0; i < SECTION_COUNT; i++) begin
      if (!sec_hit) begin
        if (sec_rem < sec_size[i]) begin
          sec_hit  = 1'b1;
          sec_addr = sec_base[i] + sec_rem;
        end else begin
          sec_rem = sec_rem - sec_size[i];
        end
      end
    end
  end

  assign sym_addr = sym_rdata + job.offset;

  // Accept stage: parse state and the job handed on. The result stage updates
  // the run state itself only for a section search, when nothing is accepted.
  always_comb begin
    phase_next      = phase;
    code_low_next   = code_low;
    pending_next    = pending;
    bytes_left_next = bytes_left;
    err_hold_next   = err_hold;
    job_in          = '0;
    job_in.kind     = rsd_pkg::JOB_NONE;
    rd_addr         = pending;

    if (accept_in && s_axis_tuser == rsd_pkg::KIND_STREAM) begin
      if (err_hold || bytes_left == 16'd0) begin
        job_in.kind     = rsd_pkg::JOB_FAIL;
        job_in.status   = rsd_pkg::STAT_RUN;
        err_hold_next   = 1'b1;
        bytes_left_next = '0;
        phase_next      = rsd_pkg::PH_NORMAL;
      end else begin
        unique case (phase)
          rsd_pkg::PH_NORMAL: begin
            if (in_byte == escape) begin
              phase_next = rsd_pkg::PH_CODE_LO;
            end else begin
              job_in.kind     = rsd_pkg::JOB_BYTE;
              job_in.data     = in_byte;
              job_in.last     = (bytes_m1 == 16'd0);
              bytes_left_next = bytes_m1;
            end
          end
          rsd_pkg::PH_CODE_LO: begin
            code_low_next = in_byte;
            phase_next    = rsd_pkg::PH_CODE_HI;
          end
          rsd_pkg::PH_OFF_LO: begin
            code_low_next = in_byte;
            phase_next    = rsd_pkg::PH_OFF_HI;
          end
          rsd_pkg::PH_CODE_HI: begin
            phase_next = rsd_pkg::PH_NORMAL;
            rd_addr    = e1[IDX_W-1:0];
            if (code == 16'd0) begin
              job_in.kind     = rsd_pkg::JOB_BYTE;
              job_in.data     = escape;
              job_in.last     = (bytes_m1 == 16'd0);
              bytes_left_next = bytes_m1;
            end else if (e1 < sym_eff) begin
              if (room_ok) begin
                job_in.kind     = rsd_pkg::JOB_SYM;
                job_in.last     = (bytes_m2 == 16'd0);
                bytes_left_next = bytes_m2;
              end else begin
                job_in.kind     = rsd_pkg::JOB_FAIL;
                job_in.status   = rsd_pkg::STAT_RUN;
                err_hold_next   = 1'b1;
                bytes_left_next = '0;
              end
            end else if (e2 < sym_eff) begin
              pending_next = e2[IDX_W-1:0];
              phase_next   = rsd_pkg::PH_OFF_LO;
            end else begin
              job_in.kind   = rsd_pkg::JOB_SEC;
              job_in.offset = e3[15:0];
            end
          end
          rsd_pkg::PH_OFF_HI: begin
            phase_next = rsd_pkg::PH_NORMAL;
            if (room_ok) begin
              job_in.kind     = rsd_pkg::JOB_SYM;
              job_in.offset   = code;
              job_in.last     = (bytes_m2 == 16'd0);
              bytes_left_next = bytes_m2;
            end else begin
              job_in.kind     = rsd_pkg::JOB_FAIL;
              job_in.status   = rsd_pkg::STAT_RUN;
              err_hold_next   = 1'b1;
              bytes_left_next = '0;
            end
          end
          default: begin
            phase_next = rsd_pkg::PH_NORMAL;
          end
        endcase
      end
    end

    if (job.kind == rsd_pkg::JOB_SEC) begin
      if (!sec_hit || !room_ok) begin
        err_hold_next   = 1'b1;
        bytes_left_next = '0;
      end else begin
        bytes_left_next = bytes_m2;
      end
    end
  end

  // Result stage: turn the job into one or two queue entries.
  always_comb begin
    res0   = '0;
    res1   = '0;
    n_push = 2'd0;
    unique case (job.kind)
      rsd_pkg::JOB_BYTE: begin
        res0 = '{data: job.data, valid: 1'b1, last: job.last, status: rsd_pkg::STAT_OK};
        n_push = 2'd1;
      end
      rsd_pkg::JOB_FAIL: begin
        res0 = '{data: 8'd0, valid: 1'b0, last: 1'b1, status: job.status};
        n_push = 2'd1;
      end
      rsd_pkg::JOB_SYM: begin
        res0 = '{data: sym_addr[7:0], valid: 1'b1, last: 1'b0, status: rsd_pkg::STAT_OK};
        res1 = '{data: sym_addr[15:8], valid: 1'b1, last: job.last, status: rsd_pkg::STAT_OK};
        n_push = 2'd2;
      end
      rsd_pkg::JOB_SEC: begin
        if (!sec_hit) begin
          res0 = '{data: 8'd0, valid: 1'b0, last: 1'b1, status: rsd_pkg::STAT_NO_SECTION};
          n_push = 2'd1;
        end else if (!room_ok) begin
          res0 = '{data: 8'd0, valid: 1'b0, last: 1'b1, status: rsd_pkg::STAT_RUN};
          n_push = 2'd1;
        end else begin
          res0 = '{data: sec_addr[7:0], valid: 1'b1, last: 1'b0, status: rsd_pkg::STAT_OK};
          res1 = '{data: sec_addr[15:8], valid: 1'b1, last: (bytes_m2 == 16'd0),
                   status: rsd_pkg::STAT_OK};
          n_push = 2'd2;
        end
      end
      default: begin
        n_push = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape       <= '0;
      symbol_count <= '0;
      phase        <= rsd_pkg::PH_NORMAL;
      code_low     <= '0;
      pending      <= '0;
      bytes_left   <= '0;
      err_hold     <= 1'b0;
      job          <= '0;
    end else begin
      job <= accept_in ? job_in : '0;
      if (cfg_we && cfg_index == rsd_pkg::REG_RUN_LEN) begin
        bytes_left <= cfg_data;
        phase      <= rsd_pkg::PH_NORMAL;
        code_low   <= '0;
        pending    <= '0;
        err_hold   <= 1'b0;
      end else begin
        phase      <= phase_next;
        code_low   <= code_low_next;
        pending    <= pending_next;
        bytes_left <= bytes_left_next;
        err_hold   <= err_hold_next;
      end
      if (cfg_we && cfg_index == rsd_pkg::REG_ESCAPE) begin
        escape <= cfg_data[7:0];
      end
      if (cfg_we && cfg_index == rsd_pkg::REG_SYM_COUNT) begin
        symbol_count <= cfg_data[8:0];
      end
    end
  end

  // Symbol memory: at most one write and one registered read per accepted request.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      sym_rdata <= sym_mem[rd_addr];
      if (s_axis_tuser == rsd_pkg::KIND_SYMBOL && tbl_idx13 < 13'(SYMBOL_DEPTH)) begin
        sym_mem[tbl_idx13[IDX_W-1:0]] <= word_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in && s_axis_tuser == rsd_pkg::KIND_SECTION &&
        tbl_idx < 8'(SECTION_COUNT)) begin
      sec_base[tbl_idx[SEC_W-1:0]] <= word_value;
      sec_size[tbl_idx[SEC_W-1:0]] <= word_size;
    end
  end

  // Result queue
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (fifo_count != '0);
  assign m_axis_tdata  = fifo_mem[rd_ptr].data;
  assign m_axis_tuser  = {fifo_mem[rd_ptr].status, fifo_mem[rd_ptr].valid};
  assign m_axis_tlast  = fifo_mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_mem[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + n_push;
      rd_ptr     <= rd_ptr + {1'b0, pop};
      fifo_count <= fifo_count + {1'b0, n_push} - {2'b0, pop};
    end
  end

  // A section search stalls the input, so the next cycle carries no job.
  assert property (@(posedge clk) disable iff (rst)
    (job.kind == rsd_pkg::JOB_SEC) |=> (job.kind == rsd_pkg::JOB_NONE))
    else $error("request accepted during section search");

  assert property (@(posedge clk) disable iff (rst)
    fifo_count <= 3'(rsd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2:1] != rsd_pkg::STAT_OK) |->
      (m_axis_tlast && !m_axis_tuser[0]))
    else $error("error result not marked as final status-only result");

endmodule
